### rtl/lcd_scanline_timing_core_macros.svh
// assertion macros for the line timing core
// no dependencies; included by files that carry assertions
`ifndef LCD_SCANLINE_TIMING_CORE_MACROS_SVH
`define LCD_SCANLINE_TIMING_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lst assertion failed");
`define LST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lst assertion failed");
`else
`define LST_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/lst_pkg.sv
// shared types, constants and helpers for the line timing core
// no dependencies
`default_nettype none
package lst_pkg;
    localparam int CD_W      = 12;
    localparam int SUM_W     = 14;
    localparam int LINE_W    = 8;
    localparam int ELAPSED_W = 10;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HBLANK_IRQ_EN = 4'd0,
        CFG_VBLANK_IRQ_EN = 4'd1,
        CFG_MATCH_IRQ_EN  = 4'd2,
        CFG_MATCH_TARGET  = 4'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                     hblank_irq;
        logic                     vblank_irq;
        logic                     line_match_irq;
        logic                     hblank_dma_start;
        logic                     vblank_dma_start;
        logic                     frame_end;
        logic [LINE_W-1:0]        line_number;
        logic                     in_hblank;
        logic                     in_vblank;
        logic                     line_match;
        logic signed [CD_W-1:0]   cycles_to_event;
    } t_rsp;

    localparam logic signed [SUM_W-1:0] CD_MIN = -14'sd2048;
    localparam logic signed [SUM_W-1:0] CD_MAX = 14'sd2047;

    function automatic logic signed [CD_W-1:0] clamp_cd(input logic signed [SUM_W-1:0] v);
        logic signed [CD_W-1:0] r;
        if (v < CD_MIN) begin
            r = CD_MIN[CD_W-1:0];
        end else if (v > CD_MAX) begin
            r = CD_MAX[CD_W-1:0];
        end else begin
            r = v[CD_W-1:0];
        end
        return r;
    endfunction
endpackage
`default_nettype wire

### rtl/lst_req_if.sv
// request channel of the line timing core: elapsed cycle count
// depends on lst_pkg
`default_nettype none
interface lst_req_if;
    logic                           valid;
    logic                           ready;
    logic [lst_pkg::ELAPSED_W-1:0]  cycles_elapsed;

    modport source (output valid, output cycles_elapsed, input ready);
    modport sink   (input valid, input cycles_elapsed, output ready);
endinterface
`default_nettype wire

### rtl/lst_rsp_if.sv
// response channel of the line timing core: pulses, flags, line and countdown
// depends on lst_pkg
`default_nettype none
interface lst_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               hblank_irq;
    logic                               vblank_irq;
    logic                               line_match_irq;
    logic                               hblank_dma_start;
    logic                               vblank_dma_start;
    logic                               frame_end;
    logic [lst_pkg::LINE_W-1:0]         line_number;
    logic                               in_hblank;
    logic                               in_vblank;
    logic                               line_match;
    logic signed [lst_pkg::CD_W-1:0]    cycles_to_event;

    modport source (
        output valid, output hblank_irq, output vblank_irq, output line_match_irq,
        output hblank_dma_start, output vblank_dma_start, output frame_end,
        output line_number, output in_hblank, output in_vblank, output line_match,
        output cycles_to_event, input ready
    );
    modport sink (
        input valid, input hblank_irq, input vblank_irq, input line_match_irq,
        input hblank_dma_start, input vblank_dma_start, input frame_end,
        input line_number, input in_hblank, input in_vblank, input line_match,
        input cycles_to_event, output ready
    );
endinterface
`default_nettype wire

### rtl/lcd_scanline_timing_core.sv
// Display line timing core.
// Depends on lst_pkg, lst_req_if, lst_rsp_if and the assertion macro header.
//
// Usage: each request on i_req carries cycles_elapsed, the cycles run since the
// previous request. The core subtracts it from a countdown; when the countdown
// reaches zero or below, one transition happens (draw to hblank, or hblank to
// the next line with vblank entry and frame wrap). Every request gives exactly
// one response on o_rsp with interrupt and DMA pulses, the line count, the
// status flags and the countdown after the request.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write it only while idle; the core does not enforce it. Throughput: one
// request per cycle while i_req is ready; the state update is a subtract, clamp,
// add, clamp and compare between the state registers and the response register.
// Stall: a two-entry output buffer (response register plus skid) keeps i_req
// ready for one more request while a response waits; ready drops only when
// both entries are full, and nothing is lost or repeated.
// Reset (synchronous, active low): countdown = DRAW_CYCLES, line 0, all flags
// and configuration registers clear, output buffer empty.
`default_nettype none
`include "lcd_scanline_timing_core_macros.svh"
module lcd_scanline_timing_core #(
    parameter int DRAW_CYCLES   = 960,
    parameter int HBLANK_CYCLES = 272,
    parameter int VISIBLE_LINES = 160,
    parameter int TOTAL_LINES   = 228
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [lst_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [lst_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    lst_req_if.sink                                 i_req,
    lst_rsp_if.source                               o_rsp
);
    localparam logic signed [lst_pkg::SUM_W-1:0] LP_DRAW   = lst_pkg::SUM_W'(DRAW_CYCLES);
    localparam logic signed [lst_pkg::SUM_W-1:0] LP_HBLANK = lst_pkg::SUM_W'(HBLANK_CYCLES);
    localparam logic [lst_pkg::LINE_W-1:0]       LP_VIS    = lst_pkg::LINE_W'(VISIBLE_LINES);
    localparam logic [lst_pkg::LINE_W-1:0]       LP_TOTAL  = lst_pkg::LINE_W'(TOTAL_LINES);

    logic                                r_hb_irq_en;
    logic                                r_vb_irq_en;
    logic                                r_match_irq_en;
    logic [lst_pkg::LINE_W-1:0]          r_target;

    logic signed [lst_pkg::CD_W-1:0]     r_cd,    n_cd;
    logic [lst_pkg::LINE_W-1:0]          r_line,  n_line;
    logic                                r_hb,    n_hb;
    logic                                r_vb,    n_vb;
    logic                                r_match, n_match;

    lst_pkg::t_rsp                       r_out, r_skid, n_rsp;
    logic                                r_out_v, r_skid_v;

    logic                                req_acc;
    logic                                rsp_take;
    logic signed [lst_pkg::SUM_W-1:0]    sub;
    logic signed [lst_pkg::CD_W-1:0]     cd1;
    logic [lst_pkg::LINE_W-1:0]          line_inc;

    assign req_acc  = i_req.valid && i_req.ready;
    assign rsp_take = r_out_v && o_rsp.ready;
    assign i_req.ready = !r_skid_v;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hb_irq_en    <= 1'b0;
            r_vb_irq_en    <= 1'b0;
            r_match_irq_en <= 1'b0;
            r_target       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lst_pkg::CFG_HBLANK_IRQ_EN: r_hb_irq_en    <= i_cfg_data[0];
                lst_pkg::CFG_VBLANK_IRQ_EN: r_vb_irq_en    <= i_cfg_data[0];
                lst_pkg::CFG_MATCH_IRQ_EN:  r_match_irq_en <= i_cfg_data[0];
                lst_pkg::CFG_MATCH_TARGET:  r_target       <= i_cfg_data[lst_pkg::LINE_W-1:0];
                default: ;
            endcase
        end
    end

    // transition logic
    always_comb begin
        sub      = $signed({{(lst_pkg::SUM_W-lst_pkg::CD_W){r_cd[lst_pkg::CD_W-1]}}, r_cd})
                 - $signed({{(lst_pkg::SUM_W-lst_pkg::ELAPSED_W){1'b0}}, i_req.cycles_elapsed});
        cd1      = lst_pkg::clamp_cd(sub);
        line_inc = r_line + 1'b1;
        n_cd     = cd1;
        n_line   = r_line;
        n_hb     = r_hb;
        n_vb     = r_vb;
        n_match  = r_match;
        n_rsp    = '0;
        if (cd1 <= 0) begin
            if (!r_hb) begin
                n_cd = lst_pkg::clamp_cd(
                    $signed({{(lst_pkg::SUM_W-lst_pkg::CD_W){cd1[lst_pkg::CD_W-1]}}, cd1})
                    + LP_HBLANK);
                n_hb = 1'b1;
                n_rsp.hblank_dma_start = !r_vb;
                n_rsp.hblank_irq       = r_hb_irq_en;
            end else begin
                n_cd = lst_pkg::clamp_cd(
                    $signed({{(lst_pkg::SUM_W-lst_pkg::CD_W){cd1[lst_pkg::CD_W-1]}}, cd1})
                    + LP_DRAW);
                n_hb   = 1'b0;
                n_line = line_inc;
                if (line_inc == LP_VIS) begin
                    n_vb = 1'b1;
                    n_rsp.vblank_dma_start = 1'b1;
                    n_rsp.vblank_irq       = r_vb_irq_en;
                end else if (line_inc >= LP_TOTAL) begin
                    n_vb   = 1'b0;
                    n_line = '0;
                    n_rsp.frame_end = 1'b1;
                end
                n_match = (n_line == r_target);
                n_rsp.line_match_irq = n_match && r_match_irq_en;
            end
        end
        n_rsp.line_number     = n_line;
        n_rsp.in_hblank       = n_hb;
        n_rsp.in_vblank       = n_vb;
        n_rsp.line_match      = n_match;
        n_rsp.cycles_to_event = n_cd;
    end

    // timing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd    <= lst_pkg::CD_W'(DRAW_CYCLES);
            r_line  <= '0;
            r_hb    <= 1'b0;
            r_vb    <= 1'b0;
            r_match <= 1'b0;
        end else if (req_acc) begin
            r_cd    <= n_cd;
            r_line  <= n_line;
            r_hb    <= n_hb;
            r_vb    <= n_vb;
            r_match <= n_match;
        end
    end

    // response register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || rsp_take) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= req_acc;
            end
        end else if (req_acc) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || rsp_take) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (req_acc) begin
                r_out <= n_rsp;
            end
        end else if (req_acc) begin
            r_skid <= n_rsp;
        end
    end

    assign o_rsp.valid            = r_out_v;
    assign o_rsp.hblank_irq       = r_out.hblank_irq;
    assign o_rsp.vblank_irq       = r_out.vblank_irq;
    assign o_rsp.line_match_irq   = r_out.line_match_irq;
    assign o_rsp.hblank_dma_start = r_out.hblank_dma_start;
    assign o_rsp.vblank_dma_start = r_out.vblank_dma_start;
    assign o_rsp.frame_end        = r_out.frame_end;
    assign o_rsp.line_number      = r_out.line_number;
    assign o_rsp.in_hblank        = r_out.in_hblank;
    assign o_rsp.in_vblank        = r_out.in_vblank;
    assign o_rsp.line_match       = r_out.line_match;
    assign o_rsp.cycles_to_event  = r_out.cycles_to_event;

    `LST_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    `LST_ASSERT_NOW(a_frame_wraps_line, i_clk, i_rst_n, r_out_v && r_out.frame_end,
        r_out.line_number == '0 && !r_out.in_vblank && !r_out.in_hblank)
    `LST_ASSERT_NOW(a_hdma_in_hblank, i_clk, i_rst_n, r_out_v && r_out.hblank_dma_start,
        r_out.in_hblank && !r_out.in_vblank)
    `LST_ASSERT_NOW(a_vdma_at_vis_line, i_clk, i_rst_n, r_out_v && r_out.vblank_dma_start,
        r_out.in_vblank && r_out.line_number == LP_VIS && !r_out.in_hblank)
    `LST_ASSERT_NEXT(a_idle_state_holds, i_clk, i_rst_n, !req_acc, $stable(r_cd) && $stable(r_line))
endmodule
`default_nettype wire
